### src/sha1_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 digest package
// Shared types, constants and helper functions for the SHA-1 digest unit.
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam int unsigned NumRounds   = 80;
  localparam int unsigned BlockWords  = 16;
  localparam int unsigned FillWidth   = 6;
  localparam int unsigned CountWidth  = 61;
  localparam int unsigned RoundWidth  = 7;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Padding leaves room for the length only when the marker lands below this.
  localparam logic [FillWidth-1:0] LEN_FIT_LIMIT = 6'd56;

  typedef enum logic [1:0] {
    GRP_CHOOSE   = 2'd0,
    GRP_PARITY_A = 2'd1,
    GRP_MAJORITY = 2'd2,
    GRP_PARITY_B = 2'd3
  } sha1_group_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_PAD_LEN,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } sha1_state_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } sha1_work_t;

  localparam sha1_work_t IV_WORK = '{a: IV0, b: IV1, c: IV2, d: IV3, e: IV4};

  function automatic sha1_group_t round_group(input logic [RoundWidth-1:0] rnd);
    sha1_group_t grp;
    if (rnd < 7'd20) begin
      grp = GRP_CHOOSE;
    end else if (rnd < 7'd40) begin
      grp = GRP_PARITY_A;
    end else if (rnd < 7'd60) begin
      grp = GRP_MAJORITY;
    end else begin
      grp = GRP_PARITY_B;
    end
    return grp;
  endfunction

  function automatic logic [31:0] round_const(input sha1_group_t grp);
    logic [31:0] k;
    unique case (grp)
      GRP_CHOOSE:   k = K0;
      GRP_PARITY_A: k = K1;
      GRP_MAJORITY: k = K2;
      GRP_PARITY_B: k = K3;
      default:      k = K0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

endpackage

### src/sha1_round.sv
// ----------------------------------------------------------------------------
// SHA-1 round unit
// One compression round: mixes the working variables with one schedule word.
// ----------------------------------------------------------------------------
module sha1_round (
  input  sha1_pkg::sha1_work_t  work_in,
  input  logic [31:0]           sched_word,
  input  sha1_pkg::sha1_group_t group_sel,
  output sha1_pkg::sha1_work_t  work_out
);
  import sha1_pkg::*;

  logic [31:0] f_val;
  logic [31:0] t_val;

  always_comb begin
    unique case (group_sel)
      GRP_CHOOSE:   f_val = (work_in.b & work_in.c) | (~work_in.b & work_in.d);
      GRP_MAJORITY: f_val = (work_in.b & work_in.c) | (work_in.b & work_in.d) |
                            (work_in.c & work_in.d);
      default:      f_val = work_in.b ^ work_in.c ^ work_in.d;
    endcase
  end

  assign t_val = rotl(work_in.a, 5) + f_val + work_in.e + round_const(group_sel) + sched_word;

  assign work_out.a = t_val;
  assign work_out.b = work_in.a;
  assign work_out.c = rotl(work_in.b, 30);
  assign work_out.d = work_in.c;
  assign work_out.e = work_in.d;

endmodule

### src/sha1_message_digest_unit.sv
// ----------------------------------------------------------------------------
// SHA-1 message digest unit: takes one byte request at a time while idle; a request that
// fills a block, or a closing request, stalls the input until the block (and any padding
// block) is compressed and, for a closing request, the digest is registered at the output;
// a digest still stalled at the output holds the unit in its output state until it is taken.
// One shared round unit runs one round per cycle. Synchronous reset loads the initial
// vector and clears the counts.
// ----------------------------------------------------------------------------
module sha1_message_digest_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_last_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word0,
  output logic [31:0] out_digest_word1,
  output logic [31:0] out_digest_word2,
  output logic [31:0] out_digest_word3,
  output logic [31:0] out_digest_word4
);
  import sha1_pkg::*;

  sha1_state_t              state_r, state_nxt;
  sha1_state_t              after_r, after_nxt;
  logic [RoundWidth-1:0]    round_r, round_nxt;
  logic [FillWidth-1:0]     fill_r, fill_nxt;
  logic [CountWidth-1:0]    count_r, count_nxt;
  logic                     out_valid_r, out_valid_nxt;
  sha1_work_t               chain_r, chain_nxt;
  sha1_work_t               work_r;
  sha1_work_t               round_out;
  sha1_work_t               digest_r;
  logic [31:0]              wbuf_r [BlockWords];

  logic                     in_accept;
  logic                     load_work;
  logic                     take_digest;
  logic [63:0]              bit_len;
  logic [31:0]              sched_new;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign bit_len   = {count_r, 3'b000};
  assign sched_new = rotl(wbuf_r[13] ^ wbuf_r[8] ^ wbuf_r[2] ^ wbuf_r[0], 1);

  sha1_round u_round (
    .work_in    (work_r),
    .sched_word (wbuf_r[0]),
    .group_sel  (round_group(round_r)),
    .work_out   (round_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      after_r     <= ST_IDLE;
      round_r     <= '0;
      fill_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      chain_r     <= IV_WORK;
    end else begin
      state_r     <= state_nxt;
      after_r     <= after_nxt;
      round_r     <= round_nxt;
      fill_r      <= fill_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      chain_r     <= chain_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    after_nxt     = after_r;
    round_nxt     = round_r;
    fill_nxt      = fill_r;
    count_nxt     = count_r;
    chain_nxt     = chain_r;
    load_work     = 1'b0;
    take_digest   = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_byte_valid) begin
            fill_nxt  = fill_r + 1'b1;
            count_nxt = count_r + 1'b1;
            // The byte completes a block: compress before anything else.
            if (fill_r == '1) begin
              state_nxt = ST_ROUND;
              after_nxt = in_last_item ? ST_PAD : ST_IDLE;
              round_nxt = '0;
              load_work = 1'b1;
            end else if (in_last_item) begin
              state_nxt = ST_PAD;
            end
          end else if (in_last_item) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        state_nxt = ST_ROUND;
        after_nxt = (fill_r >= LEN_FIT_LIMIT) ? ST_PAD_LEN : ST_OUT;
        round_nxt = '0;
        load_work = 1'b1;
      end
      ST_PAD_LEN: begin
        state_nxt = ST_ROUND;
        after_nxt = ST_OUT;
        round_nxt = '0;
        load_work = 1'b1;
      end
      ST_ROUND: begin
        round_nxt = round_r + 1'b1;
        if (round_r == RoundWidth'(NumRounds - 1)) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        chain_nxt.a = chain_r.a + work_r.a;
        chain_nxt.b = chain_r.b + work_r.b;
        chain_nxt.c = chain_r.c + work_r.c;
        chain_nxt.d = chain_r.d + work_r.d;
        chain_nxt.e = chain_r.e + work_r.e;
        state_nxt   = after_r;
      end
      ST_OUT: begin
        // Hold the digest until the previous one has been taken.
        if (!out_valid_r || !out_stall) begin
          take_digest   = 1'b1;
          out_valid_nxt = 1'b1;
          chain_nxt     = IV_WORK;
          fill_nxt      = '0;
          count_nxt     = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_work) begin
      work_r <= chain_r;
    end else if (state_r == ST_ROUND) begin
      work_r <= round_out;
    end
    if (take_digest) begin
      digest_r <= chain_r;
    end
  end

  // The block buffer doubles as the message schedule: it shifts one word per round.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_accept && in_byte_valid) begin
          for (int ln = 0; ln < 4; ln++) begin
            if (fill_r[1:0] == 2'(ln)) begin
              wbuf_r[fill_r[5:2]][31-8*ln -: 8] <= in_data_byte;
            end
          end
        end
      end
      ST_PAD: begin
        for (int wd = 0; wd < BlockWords; wd++) begin
          if ((fill_r < LEN_FIT_LIMIT) && (wd == BlockWords - 2)) begin
            wbuf_r[wd] <= bit_len[63:32];
          end else if ((fill_r < LEN_FIT_LIMIT) && (wd == BlockWords - 1)) begin
            wbuf_r[wd] <= bit_len[31:0];
          end else if (4'(wd) > fill_r[5:2]) begin
            wbuf_r[wd] <= '0;
          end else if (4'(wd) == fill_r[5:2]) begin
            for (int ln = 0; ln < 4; ln++) begin
              if (2'(ln) == fill_r[1:0]) begin
                wbuf_r[wd][31-8*ln -: 8] <= PAD_BYTE;
              end else if (2'(ln) > fill_r[1:0]) begin
                wbuf_r[wd][31-8*ln -: 8] <= 8'h00;
              end
            end
          end
        end
      end
      ST_PAD_LEN: begin
        for (int wd = 0; wd < BlockWords - 2; wd++) begin
          wbuf_r[wd] <= '0;
        end
        wbuf_r[14] <= bit_len[63:32];
        wbuf_r[15] <= bit_len[31:0];
      end
      ST_ROUND: begin
        for (int wd = 0; wd < BlockWords - 1; wd++) begin
          wbuf_r[wd] <= wbuf_r[wd+1];
        end
        wbuf_r[BlockWords-1] <= sched_new;
      end
      default: begin
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_digest_word0 = digest_r.a;
  assign out_digest_word1 = digest_r.b;
  assign out_digest_word2 = digest_r.c;
  assign out_digest_word3 = digest_r.d;
  assign out_digest_word4 = digest_r.e;

endmodule

### dv/tb_sha1_message_digest_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for sha1_message_digest_unit
// Feeds byte-wise messages of varied length and content, with bursty requests
// and a stalling receiver, and checks each digest against an in-bench SHA-1.
// ----------------------------------------------------------------------------
module tb_sha1_message_digest_unit;
  import sha1_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 8;
  localparam int LONG_HOLD      = 800;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int END_WAIT       = 200;

  typedef logic [4:0][31:0] digest_t;
  typedef enum {FILL_RANDOM, FILL_ZEROS, FILL_ONES} fill_mode_t;
  typedef enum logic [1:0] {RX_NONE, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_byte_valid = 1'b0;
  logic        in_last_item = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_digest_word0;
  logic [31:0] out_digest_word1;
  logic [31:0] out_digest_word2;
  logic [31:0] out_digest_word3;
  logic [31:0] out_digest_word4;

  sha1_message_digest_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_byte_valid    (in_byte_valid),
    .in_last_item     (in_last_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_digest_word0 (out_digest_word0),
    .out_digest_word1 (out_digest_word1),
    .out_digest_word2 (out_digest_word2),
    .out_digest_word3 (out_digest_word3),
    .out_digest_word4 (out_digest_word4)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Digest predictor state
  logic [31:0] chain_words [5];
  logic [31:0] msg_block [16];
  logic [5:0]  block_fill;
  logic [60:0] msg_len_bytes;

  digest_t pending_digests [$];
  int      mismatch_count = 0;
  int      items_sent = 0;
  int      digests_predicted = 0;
  int      burst_left = 0;
  bit      gapless_sender = 1'b0;
  logic    hold_toggle = 1'b0;

  function automatic void clear_digest_state();
    chain_words[0] = IV0;
    chain_words[1] = IV1;
    chain_words[2] = IV2;
    chain_words[3] = IV3;
    chain_words[4] = IV4;
    for (int i = 0; i < 16; i++) msg_block[i] = 32'h0;
    block_fill    = '0;
    msg_len_bytes = '0;
  endfunction

  function automatic void place_byte(input int pos, input logic [7:0] val);
    msg_block[pos >> 2][(3 - (pos & 3)) * 8 +: 8] = val;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    for (int r = 0; r < 16; r++) w[r] = msg_block[r];
    for (int r = 16; r < 80; r++) begin
      x    = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
      w[r] = {x[30:0], x[31]};
    end
    a = chain_words[0];
    b = chain_words[1];
    c = chain_words[2];
    d = chain_words[3];
    e = chain_words[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[r];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain_words[0] += a;
    chain_words[1] += b;
    chain_words[2] += c;
    chain_words[3] += d;
    chain_words[4] += e;
  endfunction

  // Advances the predictor by one accepted request; a closing request queues a digest.
  function automatic void predict_digest(input logic [7:0] data, input logic has_byte,
                                         input logic last);
    int          pos;
    logic [63:0] bit_len;
    digest_t     want;
    if (has_byte) begin
      place_byte(block_fill, data);
      block_fill    = block_fill + 6'd1;
      msg_len_bytes = msg_len_bytes + 61'd1;
      if (block_fill == 6'd0) compress_block();
    end
    if (!last) return;
    pos = block_fill;
    place_byte(pos, PAD_BYTE);
    pos++;
    // No room left for the length: finish this block and start one of zeros.
    if (pos > 56) begin
      for (int j = pos; j < 64; j++) place_byte(j, 8'h00);
      compress_block();
      pos = 0;
    end
    for (int j = pos; j < 56; j++) place_byte(j, 8'h00);
    bit_len       = {msg_len_bytes, 3'b000};
    msg_block[14] = bit_len[63:32];
    msg_block[15] = bit_len[31:0];
    compress_block();
    for (int j = 0; j < 5; j++) want[j] = chain_words[j];
    pending_digests.push_back(want);
    digests_predicted++;
    clear_digest_state();
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Offers one request in bursts with random gaps, and waits for it to be taken.
  task automatic send_request(input logic [7:0] data, input logic has_byte, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!gapless_sender) begin
        gap = $urandom_range(1, 8);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_data_byte  <= data;
    in_byte_valid <= has_byte;
    in_last_item  <= last;
    do @(posedge clk); while (in_stall);
    predict_digest(data, has_byte, last);
    items_sent++;
  endtask

  function automatic logic [7:0] pick_byte(input fill_mode_t mode);
    case (mode)
      FILL_ZEROS: return 8'h00;
      FILL_ONES:  return 8'hFF;
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Sends a whole message; empty requests are mixed in as noise.
  task automatic send_message(input int len, input fill_mode_t mode);
    bit last_has_byte;
    int plain;
    last_has_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    plain = last_has_byte ? len - 1 : len;
    for (int i = 0; i < plain; i++) begin
      if ($urandom_range(0, 11) == 0) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_request(pick_byte(mode), 1'b1, 1'b0);
    end
    send_request(last_has_byte ? pick_byte(mode) : 8'($urandom_range(0, 255)),
                 last_has_byte, 1'b1);
  endtask

  // Mostly short messages, with lengths around the padding and block edges mixed in.
  function automatic int pick_msg_len();
    int edge_lens [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(0, 16);
    if (r < 90) return edge_lens[$urandom_range(0, 9)];
    return $urandom_range(17, 140);
  endfunction

  function automatic fill_mode_t pick_fill();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return FILL_ZEROS;
    if (r == 1) return FILL_ONES;
    return FILL_RANDOM;
  endfunction

  // Receiver: random stall patterns in phases, plus a long hold on request.
  int        hold_left = 0;
  int        phase_left = 0;
  int        pattern_cnt = 0;
  logic      hold_seen = 1'b0;
  rx_mode_t  rx_mode = RX_NONE;

  always @(posedge clk) begin
    pattern_cnt <= pattern_cnt + 1;
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (phase_left == 0) begin
        rx_mode    <= rx_mode_t'($urandom_range(0, 3));
        phase_left <= $urandom_range(20, 200);
      end else begin
        phase_left <= phase_left - 1;
      end
      case (rx_mode)
        RX_NONE:     out_stall <= 1'b0;
        RX_COIN:     out_stall <= ($urandom_range(0, 1) == 1);
        RX_SPARSE:   out_stall <= ($urandom_range(0, 7) == 0);
        RX_PERIODIC: out_stall <= (pattern_cnt % 8 >= 5);
        default:     out_stall <= 1'b0;
      endcase
    end
  end

  // Digest checker
  always @(posedge clk) begin
    digest_t seen;
    digest_t want;
    if (rst_n && out_valid && !out_stall) begin
      seen[0] = out_digest_word0;
      seen[1] = out_digest_word1;
      seen[2] = out_digest_word2;
      seen[3] = out_digest_word3;
      seen[4] = out_digest_word4;
      if (pending_digests.size() == 0) begin
        report_mismatch($sformatf("digest %08x_%08x_%08x_%08x_%08x with none expected",
                                  seen[0], seen[1], seen[2], seen[3], seen[4]));
      end else begin
        want = pending_digests.pop_front();
        for (int i = 0; i < 5; i++) begin
          if (seen[i] !== want[i]) begin
            report_mismatch($sformatf("digest word%0d: got %08x, expected %08x",
                                      i, seen[i], want[i]));
          end
        end
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic wait_for_digests();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_digests.size() != 0) @(posedge clk);
  endtask

  // Empty messages, empty requests, single-byte and short messages, extreme bytes.
  task automatic test_directed();
    send_request(8'hA5, 1'b0, 1'b0);
    send_request(8'h5A, 1'b0, 1'b0);
    send_request(8'hFF, 1'b0, 1'b1);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'hFF, 1'b1, 1'b0);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hFF, 1'b0, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'hFF, 1'b1, 1'b1);
  endtask

  task automatic test_random_messages(input int n_items, input int min_digests);
    int item_goal;
    int digest_goal;
    item_goal   = items_sent + n_items;
    digest_goal = digests_predicted + min_digests;
    while (items_sent < item_goal || digests_predicted < digest_goal) begin
      gapless_sender = ($urandom_range(0, 3) == 0);
      send_message(pick_msg_len(), pick_fill());
    end
    gapless_sender = 1'b0;
  endtask

  // The receiver holds off while short messages keep coming, so the unit backs up.
  task automatic test_long_hold();
    hold_toggle <= ~hold_toggle;
    gapless_sender = 1'b1;
    for (int i = 0; i < 6; i++) send_message($urandom_range(0, 4), FILL_RANDOM);
    gapless_sender = 1'b0;
  endtask

  task automatic test_drain_pause();
    wait_for_digests();
    send_message($urandom_range(1, 10), FILL_RANDOM);
    send_message(64, FILL_RANDOM);
  endtask

  initial begin
    clear_digest_state();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_messages(460, 15);
    test_long_hold();
    test_drain_pause();
    test_random_messages(460, 15);
    wait_for_digests();
    repeat (END_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sha1_message_digest_unit.f
src/sha1_pkg.sv
src/sha1_round.sv
src/sha1_message_digest_unit.sv
dv/tb_sha1_message_digest_unit.sv
